// ===== rtl/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define BLS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bls assertion failed");

// non-overlapping implication checked outside reset
`define BLS_ASSERT_NEXT(lbl, clk, rst_n, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("bls assertion failed");

`endif

// ===== rtl/bls_pkg.sv =====
`default_nettype none

package bls_pkg;

  // field widths of the request and result
  localparam int WORD_W    = 32;
  localparam int KIND_W    = 3;
  localparam int POS_W     = 6;
  localparam int CNT_W     = 7;
  localparam int STAT_W    = 3;
  localparam int DEPTH_DEF = 64;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_PUSH   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LOCATE = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE    = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [WORD_W-1:0] value;
    logic [POS_W-1:0]         position;
  } in_req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] data;
    logic [POS_W-1:0]         found_position;
    logic [CNT_W-1:0]         count;
    logic [STAT_W-1:0]        status;
  } out_rsp_t;

  // move of the cell row: hold, shift toward the bottom taking a new top,
  // or shift toward the top with the top wrapping around to the last cell
  typedef enum logic [1:0] {
    SH_HOLD,
    SH_PUSH,
    SH_POP
  } shift_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/bls_cell.sv =====
`default_nettype none

module bls_cell
  import bls_pkg::*;
(
  input  wire logic                     clk,
  input  wire shift_op_t                shift_op,
  input  wire logic signed [WORD_W-1:0] from_prev,
  input  wire logic signed [WORD_W-1:0] from_next,
  output logic signed [WORD_W-1:0]      word
);

  logic signed [WORD_W-1:0] word_r;
  logic signed [WORD_W-1:0] word_nxt;

  // pick the neighbor word for this cycle's move
  always_comb begin
    case (shift_op)
      SH_PUSH: word_nxt = from_prev;
      SH_POP:  word_nxt = from_next;
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

`default_nettype wire

// ===== rtl/bls_ctrl.sv =====
`default_nettype none
`include "assert_macros.svh"

module bls_ctrl
  import bls_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire in_req_t                  in_req,
  input  wire logic signed [WORD_W-1:0] top_word,
  output shift_op_t                     shift_op,
  output logic                          out_valid,
  output out_rsp_t                      out_rsp
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = $clog2(DEPTH);
  localparam int EXTW = (CW > CNT_W) ? CW : CNT_W;

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [IW-1:0]            k_r, k_nxt;
  logic [IW-1:0]            tgt_r, tgt_nxt;
  logic [KIND_W-1:0]        kind_r, kind_nxt;
  logic signed [WORD_W-1:0] word_r, word_nxt;
  logic signed [WORD_W-1:0] data_r, data_nxt;
  logic                     hit_r, hit_nxt;
  logic [EXTW-1:0]          found_r, found_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_rsp_t                 out_rsp_r, out_rsp_nxt;

  logic [EXTW-1:0] count_ext;
  logic [EXTW-1:0] pos_ext;
  logic [EXTW-1:0] k_ext;
  logic [EXTW-1:0] found_now;
  logic            scan_last;
  logic            match_now;

  // scan bookkeeping: k counts rotations, so the top cell holds original cell k
  assign count_ext = EXTW'(count_r);
  assign pos_ext   = EXTW'(in_req.position);
  assign k_ext     = EXTW'(k_r);
  assign found_now = count_ext - EXTW'(1) - k_ext;
  assign scan_last = (k_r == IW'(DEPTH - 1));
  assign match_now = (k_ext < count_ext) && (top_word == word_r);

  // next state, stack count and result
  always_comb begin
    logic [EXTW-1:0] cnt_x;
    out_rsp_t        rsp;

    state_nxt     = state_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    tgt_nxt       = tgt_r;
    kind_nxt      = kind_r;
    word_nxt      = word_r;
    data_nxt      = data_r;
    hit_nxt       = hit_r;
    found_nxt     = found_r;
    out_valid_nxt = 1'b0;
    shift_op      = SH_HOLD;
    rsp           = '0;
    rsp.status    = STAT_OK;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = in_req.kind;
          case (in_req.kind)
            KIND_PUSH: begin
              if (count_r >= CW'(DEPTH)) begin
                rsp.status = STAT_FULL;
              end else begin
                shift_op  = SH_PUSH;
                count_nxt = count_r + CW'(1);
              end
            end
            KIND_POP: begin
              if (count_r == '0) begin
                rsp.status = STAT_EMPTY;
              end else begin
                shift_op  = SH_POP;
                count_nxt = count_r - CW'(1);
                rsp.data  = top_word;
              end
            end
            KIND_CLEAR: begin
              count_nxt = '0;
            end
            KIND_READ: begin
              if (pos_ext >= count_ext) begin
                rsp.status = STAT_RANGE;
              end else begin
                out_valid_nxt = 1'b0;
                state_nxt     = ST_SCAN;
                k_nxt         = '0;
                tgt_nxt       = IW'(count_ext - EXTW'(1) - pos_ext);
                data_nxt      = '0;
              end
            end
            KIND_LOCATE: begin
              if (count_r == '0) begin
                rsp.status = STAT_NOTFOUND;
              end else begin
                out_valid_nxt = 1'b0;
                state_nxt     = ST_SCAN;
                k_nxt         = '0;
                word_nxt      = in_req.value;
                hit_nxt       = 1'b0;
                found_nxt     = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        // rotate the whole row once per cycle, DEPTH times in all
        shift_op = SH_POP;
        k_nxt    = scan_last ? '0 : k_r + IW'(1);
        if (kind_r == KIND_READ) begin
          if (k_r == tgt_r) begin
            data_nxt = top_word;
          end
        end else if (match_now) begin
          // later k is a lower position, so the last match wins
          hit_nxt   = 1'b1;
          found_nxt = found_now;
        end
        if (scan_last) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (kind_r == KIND_READ) begin
            rsp.data = data_nxt;
          end else begin
            rsp.found_position = hit_nxt ? found_nxt[POS_W-1:0] : '0;
            rsp.status         = hit_nxt ? STAT_OK : STAT_NOTFOUND;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    cnt_x       = EXTW'(count_nxt);
    rsp.count   = cnt_x[CNT_W-1:0];
    out_rsp_nxt = out_valid_nxt ? rsp : out_rsp_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // scan and result payload
  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    tgt_r     <= tgt_nxt;
    kind_r    <= kind_nxt;
    word_r    <= word_nxt;
    data_r    <= data_nxt;
    hit_r     <= hit_nxt;
    found_r   <= found_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  `BLS_ASSERT(a_count_bound, clk, rst_n, count_r <= CW'(DEPTH))
  `BLS_ASSERT_NEXT(a_scan_count_stable, clk, rst_n, state_r == ST_SCAN,
    $stable(count_r))
  `BLS_ASSERT(a_result_has_cause, clk, rst_n,
    !out_valid_r || $past((start && state_r == ST_IDLE) || (state_r == ST_SCAN && scan_last)))
  `BLS_ASSERT(a_scan_starts_at_top, clk, rst_n, !$rose(busy) || k_r == '0)

endmodule

`default_nettype wire

// ===== rtl/bounded_lifo_stack_core.sv =====
`default_nettype none
// Bounded LIFO stack of signed 32-bit words, capacity DEPTH.
// Requests: drive in_req and raise start; the request is taken at a rising
// edge where start is high and busy is low. Kinds are push, pop, clear,
// read at a position from the bottom, and locate the lowest position of a
// value. Each request gives exactly one result on out_rsp, shown for a
// single cycle with out_valid high; the receiver cannot stall it.
// Push, pop, clear, unknown kinds and rejected reads or locates answer in the
// cycle after the request and a new request may follow in the next cycle.
// Read and locate rotate the row of storage cells through the top cell
// once and answer when the rotation ends; busy is high while the row rotates.
// Only the top cell has a compare and capture point, hence the rotation.
// Reset clears the entry count and any rotation in progress; the stored
// words are not cleared and are never read before a push writes them.
// Push, pop and clear are taken at 1 request per cycle while busy is low; a
// read or locate keeps busy high and takes no new request until it ends.

module bounded_lifo_stack_core
  import bls_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire in_req_t in_req,
  output logic         out_valid,
  output out_rsp_t     out_rsp
);

  shift_op_t                shift_op;
  logic signed [WORD_W-1:0] cell_word [DEPTH];

  // request sequencing, count and result
  bls_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .top_word (cell_word[0]),
    .shift_op (shift_op),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

  // row of cells, cell 0 holds the top of the stack
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_W-1:0] prev_word;
    logic signed [WORD_W-1:0] next_word;

    if (i == 0) begin : g_first
      assign prev_word = in_req.value;
    end else begin : g_mid_prev
      assign prev_word = cell_word[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_word = cell_word[0];
    end else begin : g_mid_next
      assign next_word = cell_word[i+1];
    end

    bls_cell u_cell (
      .clk      (clk),
      .shift_op (shift_op),
      .from_prev(prev_word),
      .from_next(next_word),
      .word     (cell_word[i])
    );
  end

endmodule

`default_nettype wire
